// ----- design/lhp_pkg.sv -----
package lhp_pkg;

  localparam int unsigned LAT_W  = 32;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned PROD_W = LAT_W + PCT_W;

  // Percent scale; the walk compares 100 * sum against completed * percent.
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rec_rd;
    logic rec_wr;
    logic clear;
    logic walk_init;
    logic walk_run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    div_done;
    logic    walk_end;
    logic    out_free;
  } stat_t;

  function automatic logic [LAT_W-1:0] sat_inc(input logic [LAT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ----- design/lhp_ram.sv -----
module lhp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/lhp_ctrl.sv -----
module lhp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lhp_pkg::stat_t stat_i,
  output lhp_pkg::cmd_t  cmd_o
);

  lhp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lhp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lhp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lhp_pkg::ST_DECODE;
        end
      end
      lhp_pkg::ST_DECODE: begin
        case (stat_i.action)
          lhp_pkg::ACT_RECORD: state_d = lhp_pkg::ST_DIV;
          lhp_pkg::ACT_QUERY:  state_d = lhp_pkg::ST_WALK;
          default:             state_d = lhp_pkg::ST_DONE;
        endcase
      end
      lhp_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = lhp_pkg::ST_RD;
        end
      end
      lhp_pkg::ST_RD: state_d = lhp_pkg::ST_WR;
      lhp_pkg::ST_WR: state_d = lhp_pkg::ST_DONE;
      lhp_pkg::ST_WALK: begin
        if (stat_i.walk_end) begin
          state_d = lhp_pkg::ST_DONE;
        end
      end
      lhp_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = lhp_pkg::ST_IDLE;
        end
      end
      default: state_d = lhp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      lhp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      lhp_pkg::ST_DECODE: begin
        cmd_o.walk_init = (stat_i.action == lhp_pkg::ACT_QUERY);
        cmd_o.clear     = (stat_i.action == lhp_pkg::ACT_CLEAR);
      end
      lhp_pkg::ST_DIV:  cmd_o.div_step = !stat_i.div_done;
      lhp_pkg::ST_RD:   cmd_o.rec_rd   = 1'b1;
      lhp_pkg::ST_WR:   cmd_o.rec_wr   = 1'b1;
      lhp_pkg::ST_WALK: cmd_o.walk_run = 1'b1;
      lhp_pkg::ST_DONE: cmd_o.finish   = stat_i.out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- design/lhp_dp.sv -----
module lhp_dp #(
  parameter int unsigned NUM_BINS     = 64,
  parameter int unsigned BIN_WIDTH_US = 250
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lhp_pkg::cmd_t                cmd_i,
  output lhp_pkg::stat_t               stat_o,
  input  logic [1:0]                   action_i,
  input  logic [lhp_pkg::LAT_W-1:0]    latency_us_i,
  input  logic [lhp_pkg::PCT_W-1:0]    percent_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [lhp_pkg::LAT_W-1:0]    upper_us_o,
  output logic [lhp_pkg::LAT_W-1:0]    completed_o
);

  localparam int unsigned LAT_W  = lhp_pkg::LAT_W;
  localparam int unsigned PCT_W  = lhp_pkg::PCT_W;
  localparam int unsigned PROD_W = lhp_pkg::PROD_W;
  localparam int unsigned IDX_W  = $clog2(NUM_BINS);
  localparam int unsigned ACC_W  = PROD_W + IDX_W;
  localparam int unsigned SPAN_W = $clog2(NUM_BINS * BIN_WIDTH_US);
  localparam int unsigned SHIFT  = SPAN_W + $clog2(BIN_WIDTH_US);
  localparam int unsigned RCP_W  = SPAN_W + 2;
  localparam int unsigned MUL_W  = SPAN_W + RCP_W;
  localparam logic [LAT_W-1:0] SPAN_US  = LAT_W'(NUM_BINS * BIN_WIDTH_US);
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);
  // Rounded-up reciprocal of the bin width; exact for every latency below the span.
  localparam logic [63:0] RCP_64 =
      ((64'd1 << SHIFT) + 64'(BIN_WIDTH_US) - 64'd1) / 64'(BIN_WIDTH_US);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_64);

  // Captured word.
  lhp_pkg::action_e   act_q;
  logic [LAT_W-1:0]   lat_q;
  logic [PCT_W-1:0]   pct_q;

  // Bin index.
  logic               clamp_q;
  logic               step_q;
  logic [MUL_W-1:0]   quo_mul;
  logic [IDX_W-1:0]   quo_q;
  logic [IDX_W-1:0]   bin_idx;

  // Statistics.
  logic [LAT_W-1:0]   count_q;
  logic [LAT_W-1:0]   max_q;
  logic [NUM_BINS-1:0] vbits_q;

  // Bin memory access.
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [LAT_W-1:0]   rd_data;
  logic               vb1_q;
  logic [LAT_W-1:0]   bin_eff;

  // Query walk pipeline.
  logic [PROD_W-1:0]  prod_q;
  logic [IDX_W-1:0]   addr_q;
  logic               iss_q;
  logic               v1_q, v2_q;
  logic [IDX_W-1:0]   idx1_q, idx2_q;
  logic [PROD_W-1:0]  scaled_q;
  logic [ACC_W-1:0]   acc_q, acc_sum;
  logic               tz, hit, last;
  logic [LAT_W-1:0]   edge_us;
  logic [LAT_W-1:0]   ans_q, ans_d;

  // Output register.
  logic               out_valid_q;
  logic [LAT_W-1:0]   upper_q;
  logic [LAT_W-1:0]   completed_q;
  logic               out_free;

  assign quo_mul = MUL_W'(lat_q[SPAN_W-1:0]) * MUL_W'(RECIP);
  assign bin_idx = clamp_q ? LAST_BIN : quo_q;

  assign rd_en   = cmd_i.rec_rd || (cmd_i.walk_run && iss_q);
  assign rd_addr = cmd_i.rec_rd ? bin_idx : addr_q;
  assign bin_eff = vb1_q ? rd_data : '0;

  // A bin whose valid bit is clear has not been written since the last clear and reads as zero.
  lhp_ram #(
    .WIDTH (LAT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.rec_wr),
    .wr_addr_i (bin_idx),
    .wr_data_i (lhp_pkg::sat_inc(bin_eff)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The walk ends on a zero product, at the last bin, or at the first bin where 100 * running sum
  // reaches completed * percent, which is the same bin where the sum reaches the rounded-up target.
  assign acc_sum = acc_q + ACC_W'(scaled_q);
  assign tz      = (prod_q == '0);
  assign hit     = v2_q && (acc_sum >= ACC_W'(prod_q));
  assign last    = v2_q && (idx2_q == LAST_BIN);
  assign edge_us = LAT_W'({1'b0, idx2_q} + 1'b1) * LAT_W'(BIN_WIDTH_US);

  always_comb begin
    if (tz) begin
      ans_d = '0;
    end else if (hit && !last) begin
      ans_d = edge_us;
    end else begin
      ans_d = max_q;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 1'b0;
      count_q     <= '0;
      max_q       <= '0;
      vbits_q     <= '0;
      addr_q      <= '0;
      iss_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        step_q <= 1'b1;
      end

      if (cmd_i.clear) begin
        count_q <= '0;
        max_q   <= '0;
        vbits_q <= '0;
      end else if (cmd_i.rec_wr) begin
        count_q          <= lhp_pkg::sat_inc(count_q);
        vbits_q[bin_idx] <= 1'b1;
        if (lat_q > max_q) begin
          max_q <= lat_q;
        end
      end

      if (cmd_i.walk_init) begin
        addr_q <= '0;
        iss_q  <= 1'b1;
        v1_q   <= 1'b0;
        v2_q   <= 1'b0;
      end else begin
        if (cmd_i.walk_run && iss_q) begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == LAST_BIN) begin
            iss_q <= 1'b0;
          end
        end
        v1_q <= cmd_i.walk_run && iss_q;
        v2_q <= cmd_i.walk_run && v1_q;
      end

      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= lhp_pkg::action_e'(action_i);
      lat_q   <= latency_us_i;
      pct_q   <= percent_i;
      clamp_q <= (latency_us_i >= SPAN_US);
    end else if (cmd_i.div_step) begin
      quo_q <= IDX_W'(quo_mul >> SHIFT);
    end

    if (rd_en) begin
      vb1_q <= vbits_q[rd_addr];
    end

    if (cmd_i.walk_init) begin
      prod_q <= PROD_W'(count_q) * PROD_W'(pct_q);
      acc_q  <= '0;
    end else if (cmd_i.walk_run && v2_q) begin
      acc_q <= acc_sum;
    end

    idx1_q   <= addr_q;
    idx2_q   <= idx1_q;
    scaled_q <= PROD_W'(bin_eff) * PROD_W'(lhp_pkg::PCT_SCALE);

    if (cmd_i.walk_run) begin
      ans_q <= ans_d;
    end

    if (cmd_i.finish) begin
      upper_q     <= (act_q == lhp_pkg::ACT_QUERY) ? ans_q : '0;
      completed_q <= count_q;
    end
  end

  assign stat_o.action   = act_q;
  assign stat_o.div_done = step_q;
  assign stat_o.walk_end = tz || hit || last;
  assign stat_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign upper_us_o  = upper_q;
  assign completed_o = completed_q;

endmodule

// ----- design/latency_histogram_percentile.sv -----
// Latency histogram with percentile readout. One word is handled at a time. A record
// word finds its bin with one registered multiplication by the reciprocal of the bin
// width and then does a read-modify-write of the bin memory. A query word walks the
// bin memory one bin per cycle through a three-stage read, scale and accumulate
// pipeline, and finishes early once the percentile bin is found or the requested
// count is zero. A clear word or the unused action code goes from decode straight to
// the result. Reset and clear take effect at once through per-bin valid bits, with no
// clearing pass. The result register lets the next word be accepted while a result is
// still stalled at the output.
module latency_histogram_percentile #(
  parameter int unsigned NUM_BINS     = 64,
  parameter int unsigned BIN_WIDTH_US = 250
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] latency_us_i,
  input  logic [6:0]  percent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] upper_us_o,
  output logic [31:0] completed_o
);

  lhp_pkg::cmd_t  cmd;
  lhp_pkg::stat_t stat;

  lhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lhp_dp #(
    .NUM_BINS     (NUM_BINS),
    .BIN_WIDTH_US (BIN_WIDTH_US)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (action_i),
    .latency_us_i (latency_us_i),
    .percent_i    (percent_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .upper_us_o   (upper_us_o),
    .completed_o  (completed_o)
  );

endmodule

// ----- design/lhp_chk.sv -----
module lhp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  action_i,
  input logic [31:0] latency_us_i,
  input logic [6:0]  percent_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] upper_us_o,
  input logic [31:0] completed_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(upper_us_o) && $stable(completed_o))
    else $error("result word changed while stalled");

  // Only one word is in flight, so the input stalls right after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while one is in flight");

  // No result can appear in the cycle right after an accept.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early after accept");

  // An idle block with no incoming word produces no result.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !in_valid_i |=> !$rose(out_valid_o))
    else $error("result appeared with no word in flight");

endmodule

bind latency_histogram_percentile lhp_chk u_lhp_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NUM_BINS     = 64;
  localparam int unsigned BIN_WIDTH_US = 250;
  localparam int unsigned IDX_W        = $clog2(NUM_BINS);
  localparam int unsigned LAST_EDGE    = (NUM_BINS - 1) * BIN_WIDTH_US;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PRINT_CAP    = 40;

  typedef struct {
    logic [31:0] upper;
    logic [31:0] completed;
  } result_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i     = lhp_pkg::ACT_NONE;
  logic [31:0] latency_us_i = '0;
  logic [6:0]  percent_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [31:0] upper_us_o;
  logic [31:0] completed_o;

  // Histogram as the block should hold it.
  logic [31:0] bin_cnt [NUM_BINS];
  logic [31:0] completed_cnt;
  logic [31:0] max_lat;

  result_t     awaited_q[$];
  result_t     head;
  int unsigned fail_count   = 0;
  int unsigned words_seen   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_run    = 0;
  bit          idling_on    = 1'b1;

  latency_histogram_percentile #(
    .NUM_BINS    (NUM_BINS),
    .BIN_WIDTH_US(BIN_WIDTH_US)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .latency_us_i(latency_us_i),
    .percent_i   (percent_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .upper_us_o  (upper_us_o),
    .completed_o (completed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_histogram();
    for (int i = 0; i < NUM_BINS; i++) bin_cnt[IDX_W'(i)] = '0;
    completed_cnt = '0;
    max_lat       = '0;
  endfunction

  // Updates the histogram for one word and returns the result it must produce.
  function automatic result_t histogram_step(lhp_pkg::action_e act, logic [31:0] lat,
                                             logic [6:0] pct);
    result_t         res;
    int unsigned     idx;
    longint unsigned target;
    longint unsigned running;
    bit              found;
    res.upper = '0;
    case (act)
      lhp_pkg::ACT_RECORD: begin
        idx = lat / BIN_WIDTH_US;
        if (idx > NUM_BINS - 1) idx = NUM_BINS - 1;
        if (completed_cnt != '1) completed_cnt = completed_cnt + 1;
        if (bin_cnt[IDX_W'(idx)] != '1) bin_cnt[IDX_W'(idx)] = bin_cnt[IDX_W'(idx)] + 1;
        if (lat > max_lat) max_lat = lat;
      end
      lhp_pkg::ACT_QUERY: begin
        target  = (longint'(completed_cnt) * longint'(pct) + 64'd99) / 64'd100;
        running = 0;
        found   = 1'b0;
        if (target != 0) begin
          res.upper = max_lat;
          for (int i = 0; i < NUM_BINS; i++) begin
            running += bin_cnt[IDX_W'(i)];
            if (!found && running >= target) begin
              found = 1'b1;
              if (i != NUM_BINS - 1) res.upper = (i + 1) * BIN_WIDTH_US;
            end
          end
        end
      end
      lhp_pkg::ACT_CLEAR: clear_histogram();
      default: ;
    endcase
    res.completed = completed_cnt;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("[%0t] result %0d: %s got %0d, expected %0d", $time, words_seen, what,
               got, want);
    fail_count++;
  endtask

  // Mostly back to back, now and then a gap long enough to span a whole walk.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  task automatic send_word(input lhp_pkg::action_e act, input logic [31:0] lat,
                           input logic [6:0] pct);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    latency_us_i <= lat;
    percent_i    <= pct;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_q.push_back(histogram_step(act, lat, pct));
  endtask

  // Output side: random back-pressure, mostly short bursts.
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else if (idling_on && $urandom_range(0, 99) < 20) begin
      out_stall_i <= 1'b1;
      stall_run   <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (awaited_q.size() == 0) begin
        report_mismatch("unexpected word, completed", completed_o, '0);
      end else begin
        head = awaited_q.pop_front();
        if (upper_us_o !== head.upper)
          report_mismatch("upper_us", upper_us_o, head.upper);
        if (completed_o !== head.completed)
          report_mismatch("completed", completed_o, head.completed);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_latency();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 2000);
      1: return $urandom_range(0, LAST_EDGE + 750);
      2: return $urandom;
      // At or next to a bin edge; an offset below zero wraps to the largest latency.
      3: return $urandom_range(0, NUM_BINS) * BIN_WIDTH_US + $urandom_range(0, 2) - 1;
      default: return $urandom_range(LAST_EDGE, 100_000);
    endcase
  endfunction

  function automatic logic [6:0] pick_percent();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 7'd0;
    if (r < 20) return 7'd100;
    if (r < 30) return 7'($urandom_range(101, 127));
    return 7'($urandom_range(1, 99));
  endfunction

  task automatic test_empty_state();
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd50);
    send_word(lhp_pkg::ACT_QUERY, '1, 7'd127);
  endtask

  task automatic test_bin_edges();
    send_word(lhp_pkg::ACT_RECORD, 32'd0, 7'd0);
    send_word(lhp_pkg::ACT_RECORD, BIN_WIDTH_US - 1, 7'd127);
    send_word(lhp_pkg::ACT_RECORD, BIN_WIDTH_US, 7'd0);
    send_word(lhp_pkg::ACT_RECORD, LAST_EDGE - 1, 7'd0);
    send_word(lhp_pkg::ACT_RECORD, LAST_EDGE, 7'd0);
    send_word(lhp_pkg::ACT_RECORD, 32'hFFFF_FFFF, 7'd127);
  endtask

  // Zero, lowest, middle, top and above-100 percentiles; the last runs out of bins.
  task automatic test_percentiles();
    send_word(lhp_pkg::ACT_QUERY, 32'hFFFF_FFFF, 7'd0);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd1);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd50);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd99);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd100);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd127);
  endtask

  task automatic test_unused_action();
    send_word(lhp_pkg::ACT_NONE, 32'hFFFF_FFFF, 7'd127);
    send_word(lhp_pkg::ACT_NONE, 32'd0, 7'd100);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd100);
  endtask

  task automatic test_clear();
    send_word(lhp_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 7'd127);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd100);
    send_word(lhp_pkg::ACT_RECORD, 32'd500, 7'd0);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd100);
    send_word(lhp_pkg::ACT_QUERY, '0, 7'd101);
  endtask

  // Mostly records so the bins fill up, with queries spread across the range.
  task automatic test_random_traffic(input int unsigned n_words,
                                     input int unsigned clear_weight);
    int unsigned r;
    for (int unsigned k = 0; k < n_words; k++) begin
      r = $urandom_range(0, 99);
      if (r < clear_weight)
        send_word(lhp_pkg::ACT_CLEAR, $urandom, 7'($urandom));
      else if (r < clear_weight + 4)
        send_word(lhp_pkg::ACT_NONE, $urandom, 7'($urandom));
      else if (r < clear_weight + 30)
        send_word(lhp_pkg::ACT_QUERY, $urandom, pick_percent());
      else
        send_word(lhp_pkg::ACT_RECORD, pick_latency(), 7'($urandom));
    end
  endtask

  task automatic test_no_idling(input int unsigned n_words);
    idling_on = 1'b0;
    test_random_traffic(n_words, 2);
    idling_on = 1'b1;
  endtask

  initial begin
    clear_histogram();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_state();
    test_bin_edges();
    test_percentiles();
    test_unused_action();
    test_clear();
    test_random_traffic(550, 1);
    test_random_traffic(450, 4);
    test_no_idling(250);
    test_random_traffic(150, 0);

    in_valid_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lhp_pkg.sv
design/lhp_ram.sv
design/lhp_ctrl.sv
design/lhp_dp.sv
design/latency_histogram_percentile.sv
design/lhp_chk.sv
tb/tb.sv
